>>> rtl/bcx_pkg.sv
// shared constants, types and helpers for the bencode info dictionary extractor
package bcx_pkg;

   localparam int unsigned DEF_MAX_DEPTH   = 16;
   localparam int unsigned DEF_LENGTH_BITS = 32;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6c;

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_DICT   = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_OVER   = 2'd3;

   localparam logic [1:0] TK_NONE = 2'd0;
   localparam logic [1:0] TK_LEN  = 2'd1;
   localparam logic [1:0] TK_BODY = 2'd2;
   localparam logic [1:0] TK_INT  = 2'd3;

   localparam logic [1:0] ST_DATA       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_UNTERM     = 2'd2;
   localparam logic [1:0] ST_TOO_DEEP   = 2'd3;

   localparam logic [2:0] KEY_LAST = 3'd6;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_dict;
      logic [1:0] status;
   } bcx_result_type;

   // key pattern 4:infod
   function automatic logic [7:0] key_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = CH_FOUR;
         3'd1: ch = CH_COLON;
         3'd2: ch = CH_I;
         3'd3: ch = CH_N;
         3'd4: ch = CH_F;
         3'd5: ch = CH_O;
         3'd6: ch = CH_D;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

>>> rtl/bcx_scan.sv
// scanning state and per-byte decode producing at most one result per transaction
module bcx_scan #(
   parameter int unsigned MAX_DEPTH   = bcx_pkg::DEF_MAX_DEPTH,
   parameter int unsigned LENGTH_BITS = bcx_pkg::DEF_LENGTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   input  logic                   in_start,
   input  logic                   in_end,
   output logic                   res_valid,
   output bcx_pkg::bcx_result_type res
);
   import bcx_pkg::*;

   localparam int unsigned DEPTH_BITS = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = DEPTH_BITS'(MAX_DEPTH);

   logic [1:0]             phase_ff, phase_in, phase_cur;
   logic [2:0]             match_ff, match_in, match_cur;
   logic [1:0]             token_ff, token_in, token_cur;
   logic [LENGTH_BITS-1:0] length_ff, length_in, length_cur;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in, depth_cur, depth_dec;
   logic [LENGTH_BITS+3:0] length_ext;
   logic [3:0]             digit;

   assign digit      = in_byte[3:0];
   assign length_ext = ({4'b0000, length_cur} << 3) + ({4'b0000, length_cur} << 1)
                     + {{LENGTH_BITS{1'b0}}, digit};
   assign depth_dec  = (depth_cur != '0) ? depth_cur - 1'b1 : depth_cur;

   always_comb begin
      phase_cur  = in_start ? PH_SEARCH : phase_ff;
      match_cur  = in_start ? 3'd0 : match_ff;
      token_cur  = in_start ? TK_NONE : token_ff;
      length_cur = in_start ? '0 : length_ff;
      depth_cur  = in_start ? '0 : depth_ff;

      phase_in  = phase_cur;
      match_in  = match_cur;
      token_in  = token_cur;
      length_in = length_cur;
      depth_in  = depth_cur;

      res_valid        = 1'b0;
      res.out_byte     = in_byte;
      res.last_of_dict = 1'b0;
      res.status       = ST_DATA;

      if (in_end) begin
         res.out_byte = 8'h00;
         case (phase_cur)
            PH_SEARCH: begin
               res_valid  = 1'b1;
               res.status = ST_NOT_FOUND;
            end
            PH_DICT: begin
               res_valid  = 1'b1;
               res.status = ST_UNTERM;
            end
            PH_OVER: begin
               res_valid  = 1'b1;
               res.status = ST_TOO_DEEP;
            end
            default: res_valid = 1'b0;
         endcase
         phase_in  = PH_SEARCH;
         match_in  = 3'd0;
         token_in  = TK_NONE;
         length_in = '0;
         depth_in  = '0;
      end else begin
         case (phase_cur)
            PH_SEARCH: begin
               if (in_byte == key_char(match_cur)) begin
                  if (match_cur == KEY_LAST) begin
                     match_in  = 3'd0;
                     phase_in  = PH_DICT;
                     depth_in  = DEPTH_BITS'(1);
                     token_in  = TK_NONE;
                     length_in = '0;
                     res_valid = 1'b1;
                  end else begin
                     match_in = match_cur + 3'd1;
                  end
               end else begin
                  match_in = (in_byte == CH_FOUR) ? 3'd1 : 3'd0;
               end
            end
            PH_DICT: begin
               res_valid = 1'b1;
               case (token_cur)
                  TK_LEN: begin
                     if (is_digit(in_byte)) begin
                        length_in = (length_ext[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000)
                                  ? '1 : length_ext[LENGTH_BITS-1:0];
                     end else if (in_byte == CH_COLON) begin
                        token_in = (length_cur == '0) ? TK_NONE : TK_BODY;
                     end
                  end
                  TK_BODY: begin
                     length_in = length_cur - 1'b1;
                     if (length_cur == LENGTH_BITS'(1)) token_in = TK_NONE;
                  end
                  TK_INT: begin
                     if (in_byte == CH_E) token_in = TK_NONE;
                  end
                  default: begin
                     if (in_byte == CH_E) begin
                        depth_in = depth_dec;
                        if (depth_dec == '0) begin
                           phase_in         = PH_DONE;
                           res.last_of_dict = 1'b1;
                        end
                     end else if (is_digit(in_byte)) begin
                        token_in  = TK_LEN;
                        length_in = {{(LENGTH_BITS-4){1'b0}}, digit};
                     end else if (in_byte == CH_I) begin
                        token_in = TK_INT;
                     end else if (in_byte == CH_D || in_byte == CH_L) begin
                        if (depth_cur >= DEPTH_LIMIT) begin
                           phase_in  = PH_OVER;
                           res_valid = 1'b0;
                        end else begin
                           depth_in = depth_cur + 1'b1;
                        end
                     end
                  end
               endcase
            end
            default: res_valid = 1'b0;
         endcase
      end

      if (!in_valid) res_valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         match_ff  <= 3'd0;
         token_ff  <= TK_NONE;
         length_ff <= '0;
         depth_ff  <= '0;
      end else if (in_valid) begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         token_ff  <= token_in;
         length_ff <= length_in;
         depth_ff  <= depth_in;
      end
   end

endmodule

>>> rtl/bcx_out.sv
// two-entry result buffer between the scanner and the result channel
module bcx_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bcx_pkg::bcx_result_type push_data,
   output logic                    push_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bcx_pkg::bcx_result_type out_data
);
   import bcx_pkg::*;

   logic [1:0]     count_ff, count_in;
   bcx_result_type head_ff, head_in, tail_ff, tail_in;
   logic           pop;

   assign pop        = (count_ff != 2'd0) && out_ready;
   assign push_ready = (count_ff != 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign out_data   = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         2'b10: begin
            if (count_ff == 2'd0) head_in = push_data;
            else tail_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

>>> rtl/bencode_info_dict_extractor_top.sv
// top level of the bencode info dictionary extractor
//
//   channel  direction  contents
//   req_     in         in_byte, start_of_document, end_of_document
//   rsp_     out        out_byte, last_of_dict, status
//
// one transaction per ready cycle; a byte decodes in the cycle it is taken
// and any result lands in a two-entry output buffer, visible the next cycle
// reset is synchronous and returns the scanner to the key search, buffer empty
// req_ready drops only while both buffer entries hold results not yet taken
module bencode_info_dict_extractor_top #(
   parameter int unsigned MAX_DEPTH   = bcx_pkg::DEF_MAX_DEPTH,
   parameter int unsigned LENGTH_BITS = bcx_pkg::DEF_LENGTH_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_of_document,
   input  logic       req_end_of_document,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_dict,
   output logic [1:0] rsp_status
);
   import bcx_pkg::*;

   logic           accept;
   logic           res_valid;
   bcx_result_type res;
   bcx_result_type rsp_data;

   assign accept = req_valid && req_ready;

   bcx_scan #(
      .MAX_DEPTH   (MAX_DEPTH),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_in_byte),
      .in_start  (req_start_of_document),
      .in_end    (req_end_of_document),
      .res_valid (res_valid),
      .res       (res)
   );

   bcx_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_last_of_dict = rsp_data.last_of_dict;
   assign rsp_status       = rsp_data.status;

endmodule
